// ===== design/tcbn_pkg.sv =====
// Shared codes for the two-compartment burst neuron: register indexes and spike kinds.
`timescale 1ns / 1ps

package tcbn_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_SOMA_LEVELS   = 3'd0,
    CFG_SOMA_GAINS    = 3'd1,
    CFG_ADAPT_GAINS   = 3'd2,
    CFG_APICAL_LEVELS = 3'd3,
    CFG_APICAL_GAINS  = 3'd4,
    CFG_TIMING        = 3'd5,
    CFG_APICAL_ENABLE = 3'd6
  } cfg_index_t;

  // Spike kind codes on the result stream
  typedef enum logic [2:0] {
    KIND_NONE        = 3'd0,
    KIND_REGULAR     = 3'd1,
    KIND_BURST_START = 3'd2,
    KIND_BURST_CONT  = 3'd3,
    KIND_BURST_END   = 3'd4
  } spike_kind_t;

  localparam int unsigned COUNT_BITS = 11;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = 11'd2047;

endpackage

// ===== design/two_compartment_burst_neuron_unit.sv =====
// Two-compartment adaptive LIF neuron with bursting, pipelined one neuron per cycle when not stalled.
`timescale 1ns / 1ps
//
//  channel   direction  handshake                    payload
//  s_axis    in         s_axis_tvalid/s_axis_tready  tdata: index, currents; tlast: end of tick
//  m_axis    out        m_axis_tvalid/m_axis_tready  tdata: id, count; tuser: fired, kind
//  cfg       in         cfg_valid/cfg_ready          cfg_index, cfg_data
//
//  Updates for distinct neurons are taken one per cycle while the output is not stalled;
//  a result passes ten pipeline stages and the output register. The state memory has one
//  write port at the last stage, so an update for a neuron still in the pipeline waits
//  until the earlier one is written. After reset a clearing pass writes zero state to all
//  NEURONS entries, one per cycle, and no update is taken meanwhile.
//  A stalled output holds its result; stages behind it keep filling empty slots.

module two_compartment_burst_neuron_unit #(
  parameter int NEURONS    = 1024,
  parameter int VALUE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [9:0] neuron_index, [25:10] basal_current, [41:26] apical_current,
  // [57:42] soma_current, [63:58] zero
  input  logic [63:0] s_axis_tdata,
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [9:0] neuron_id, [20:10] tick_fire_count, [23:21] zero
  output logic [23:0] m_axis_tdata,
  // [0] fired, [3:1] spike_kind
  output logic [3:0]  m_axis_tuser,
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import tcbn_pkg::*;

  localparam int VB   = VALUE_BITS;
  localparam int MV   = (VB > 17) ? VB : 17;
  localparam int WW   = MV + 10;
  localparam int PW   = WW + 16;
  localparam int AW   = (NEURONS > 1) ? $clog2(NEURONS) : 1;
  localparam int NSTG = 10;

  localparam logic signed [WW-1:0] VMAX = {{(WW-VB+1){1'b0}}, {(VB-1){1'b1}}};
  localparam logic signed [WW-1:0] VMIN = ~VMAX;
  localparam logic signed [PW-1:0] HALF12 = 2048;
  localparam logic signed [WW-1:0] HALF5 = 16;
  localparam logic signed [WW-1:0] HALF4 = 8;

  typedef struct packed {
    logic signed [VB-1:0] v;
    logic signed [VB-1:0] va;
    logic signed [VB-1:0] w;
    logic [15:0]          refr;
    logic                 ca;
    logic [15:0]          cal;
    logic [15:0]          burst;
    logic [15:0]          intv;
  } nstate_t;

  typedef struct packed {
    logic [9:0]           idx;
    logic                 inr;
    logic                 last;
    logic signed [16:0]   drive;
    logic signed [15:0]   iap;
    nstate_t              st;
    logic signed [VB-1:0] vi;
    logic signed [VB-1:0] wi;
    logic signed [PW-1:0] pa;
    logic signed [PW-1:0] pb;
    logic signed [PW-1:0] pr;
    logic signed [PW-1:0] pm;
  } item_t;

  function automatic logic signed [WW-1:0] xv(input logic signed [VB-1:0] a);
    return {{(WW-VB){a[VB-1]}}, a};
  endfunction

  function automatic logic signed [WW-1:0] x16(input logic signed [15:0] a);
    return {{(WW-16){a[15]}}, a};
  endfunction

  function automatic logic signed [VB-1:0] sat(input logic signed [WW-1:0] a);
    if (a > VMAX) begin
      return VMAX[VB-1:0];
    end else if (a < VMIN) begin
      return VMIN[VB-1:0];
    end else begin
      return a[VB-1:0];
    end
  endfunction

  function automatic logic signed [PW-1:0] mul(input logic signed [15:0] g,
                                               input logic signed [WW-1:0] a);
    return g * a;
  endfunction

  // round to nearest, halves up, of p / 4096
  function automatic logic signed [WW-1:0] rnd(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] t;
    t = p + HALF12;
    return t[WW+11:12];
  endfunction

  // Configuration registers
  logic [47:0] soma_levels, soma_gains, adapt_gains, apical_gains;
  logic [31:0] apical_levels;
  logic [63:0] timing;
  logic        apical_enable;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      soma_levels   <= '0;
      soma_gains    <= '0;
      adapt_gains   <= '0;
      apical_levels <= '0;
      apical_gains  <= '0;
      timing        <= '0;
      apical_enable <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SOMA_LEVELS:   soma_levels   <= cfg_data[47:0];
        CFG_SOMA_GAINS:    soma_gains    <= cfg_data[47:0];
        CFG_ADAPT_GAINS:   adapt_gains   <= cfg_data[47:0];
        CFG_APICAL_LEVELS: apical_levels <= cfg_data[31:0];
        CFG_APICAL_GAINS:  apical_gains  <= cfg_data[47:0];
        CFG_TIMING:        timing        <= cfg_data;
        CFG_APICAL_ENABLE: apical_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Unpack register fields
  logic signed [15:0] lvl_rest, lvl_thr, lvl_reset, g_m, r_s, k_f, a_s, b_j, g_w;
  logic signed [15:0] ca_thr, ca_jump, g_a, r_a, k_b;
  logic [15:0] t_ref, t_cal, t_cnt, t_int;
  logic signed [VB-1:0] vrest, vreset;

  assign lvl_rest  = soma_levels[15:0];
  assign lvl_thr   = soma_levels[31:16];
  assign lvl_reset = soma_levels[47:32];
  assign g_m       = soma_gains[15:0];
  assign r_s       = soma_gains[31:16];
  assign k_f       = soma_gains[47:32];
  assign a_s       = adapt_gains[15:0];
  assign b_j       = adapt_gains[31:16];
  assign g_w       = adapt_gains[47:32];
  assign ca_thr    = apical_levels[15:0];
  assign ca_jump   = apical_levels[31:16];
  assign g_a       = apical_gains[15:0];
  assign r_a       = apical_gains[31:16];
  assign k_b       = apical_gains[47:32];
  assign t_ref     = timing[15:0];
  assign t_cal     = timing[31:16];
  assign t_cnt     = timing[47:32];
  assign t_int     = timing[63:48];
  assign vrest     = sat(x16(lvl_rest));
  assign vreset    = sat(x16(lvl_reset));

  // Pipeline storage
  item_t           pipe [1:NSTG];
  item_t           nx   [1:NSTG];
  logic [NSTG:1]   vld;
  logic            ld   [1:NSTG+1];
  nstate_t         mem  [0:NEURONS-1];
  nstate_t         rd;
  logic            clearing;
  logic [AW-1:0]   clr_cnt;
  logic            ov, o_fired, o_last;
  logic [9:0]      o_idx;
  spike_kind_t     o_kind;
  logic [COUNT_BITS-1:0] o_cnt, cnt, cnt_next;
  logic [9:0]      s_idx;
  logic            haz, acc, go_last, we;
  logic [AW-1:0]   waddr;
  nstate_t         wdata;
  nstate_t         dec_st;
  logic            dec_fired;
  spike_kind_t     dec_kind;

  assign s_idx = s_axis_tdata[9:0];

  // Stall chain: a stage loads when it is empty or its successor moves
  always_comb begin
    ld[NSTG+1] = !ov || m_axis_tready;
    for (int k = NSTG; k >= 1; k--) begin
      ld[k] = !vld[k] || ld[k+1];
    end
  end

  // Hold a request whose neuron is still in flight
  always_comb begin
    haz = 1'b0;
    for (int k = 1; k <= NSTG; k++) begin
      if (vld[k] && pipe[k].inr && (pipe[k].idx == s_idx)) begin
        haz = 1'b1;
      end
    end
  end

  assign s_axis_tready = ld[1] && !haz && !clearing;
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign go_last       = vld[NSTG] && ld[NSTG+1];

  // Stage logic
  always_comb begin
    logic signed [WW-1:0] suma, sums;
    logic signed [VB-1:0] vai, vas;

    // accept
    nx[1]       = '0;
    nx[1].idx   = s_idx;
    nx[1].inr   = (32'(s_idx) < NEURONS);
    nx[1].last  = s_axis_tlast;
    nx[1].drive = {s_axis_tdata[25], s_axis_tdata[25:10]}
                + {s_axis_tdata[57], s_axis_tdata[57:42]};
    nx[1].iap   = s_axis_tdata[41:26];

    // load state, apical drive and coupling, soma drive products
    nx[2]    = pipe[1];
    nx[2].st = rd;
    nx[2].pa = mul(r_a, x16(pipe[1].iap));
    nx[2].pb = mul(k_b, xv(rd.v) - xv(rd.va));
    nx[2].pr = mul(r_s, {{(WW-17){pipe[1].drive[16]}}, pipe[1].drive});

    // apical leak sum times gain
    nx[3]    = pipe[2];
    suma     = (xv(vrest) - xv(pipe[2].st.va)) + rnd(pipe[2].pa) + rnd(pipe[2].pb);
    nx[3].pm = mul(g_a, suma);

    // apical voltage and calcium timer
    nx[4] = pipe[3];
    vai   = sat(xv(pipe[3].st.va) + rnd(pipe[3].pm));
    if (apical_enable) begin
      if (pipe[3].st.cal != 16'd0) begin
        nx[4].st.cal = pipe[3].st.cal - 16'd1;
        if (pipe[3].st.cal == 16'd1) begin
          nx[4].st.ca = 1'b0;
        end
      end else if (xv(vai) >= x16(ca_thr)) begin
        nx[4].st.ca  = 1'b1;
        nx[4].st.cal = t_cal;
        vai          = sat(xv(vai) + x16(ca_jump));
      end
      nx[4].st.va = vai;
    end

    // forward coupling product
    nx[5]    = pipe[4];
    vas      = apical_enable ? pipe[4].st.va : vrest;
    nx[5].pm = mul(k_f, xv(vas) - xv(pipe[4].st.v));

    // soma sum times membrane gain
    nx[6]    = pipe[5];
    sums     = (xv(vrest) - xv(pipe[5].st.v)) + rnd(pipe[5].pr) - xv(pipe[5].st.w)
             + rnd(pipe[5].pm);
    nx[6].pm = mul(g_m, sums);

    // integrated soma voltage
    nx[7]    = pipe[6];
    nx[7].vi = sat(xv(pipe[6].st.v) + rnd(pipe[6].pm));

    // adaptation drive
    nx[8]    = pipe[7];
    nx[8].pm = mul(a_s, xv(pipe[7].vi) - xv(vrest));

    // adaptation step times gain
    nx[9]    = pipe[8];
    nx[9].pm = mul(g_w, rnd(pipe[8].pm) - xv(pipe[8].st.w));

    // integrated adaptation current
    nx[10]    = pipe[9];
    nx[10].wi = sat(xv(pipe[9].st.w) + rnd(pipe[9].pm));
  end

  // Burst, refractory and threshold decision on the last stage
  always_comb begin
    logic                 integ, expired;
    logic signed [VB-1:0] wsel;
    logic signed [WW-1:0] t5, t4;
    integ     = (pipe[NSTG].st.refr == 16'd0);
    expired   = (pipe[NSTG].st.intv <= 16'd1);
    wsel      = integ ? pipe[NSTG].wi : pipe[NSTG].st.w;
    t5        = (x16(b_j) + HALF5) >>> 5;
    t4        = (x16(b_j) + HALF4) >>> 4;
    dec_st    = pipe[NSTG].st;
    dec_fired = 1'b0;
    dec_kind  = KIND_NONE;
    priority if (pipe[NSTG].st.burst != 16'd0) begin
      dec_st.intv = expired ? t_int : pipe[NSTG].st.intv - 16'd1;
      if (!integ) begin
        dec_st.refr = pipe[NSTG].st.refr - 16'd1;
      end
      dec_st.v = integ ? pipe[NSTG].vi : pipe[NSTG].st.v;
      dec_st.w = wsel;
      if (expired) begin
        dec_st.burst = pipe[NSTG].st.burst - 16'd1;
        dec_st.v     = vreset;
        dec_st.w     = sat(xv(wsel) + t5);
        dec_kind     = (pipe[NSTG].st.burst == 16'd1) ? KIND_BURST_END : KIND_BURST_CONT;
        dec_fired    = 1'b1;
      end
    end else if (!integ) begin
      dec_st.refr = pipe[NSTG].st.refr - 16'd1;
    end else begin
      dec_st.v = pipe[NSTG].vi;
      dec_st.w = pipe[NSTG].wi;
      if (xv(pipe[NSTG].vi) >= x16(lvl_thr)) begin
        dec_st.v    = vreset;
        dec_st.w    = sat(xv(pipe[NSTG].wi) + t4);
        dec_st.refr = t_ref;
        dec_fired   = 1'b1;
        if (apical_enable && pipe[NSTG].st.ca) begin
          dec_kind     = KIND_BURST_START;
          dec_st.burst = (t_cnt != 16'd0) ? t_cnt - 16'd1 : 16'd0;
          dec_st.intv  = t_int;
        end else begin
          dec_kind = KIND_REGULAR;
        end
      end
    end
    if (!pipe[NSTG].inr) begin
      dec_fired = 1'b0;
      dec_kind  = KIND_NONE;
    end
  end

  // Running spike count for the tick
  always_comb begin
    cnt_next = cnt;
    if (dec_fired && (cnt != COUNT_MAX)) begin
      cnt_next = cnt + 1'b1;
    end
  end

  // State memory: clearing pass, then last-stage write back
  assign we    = clearing || (go_last && pipe[NSTG].inr);
  assign waddr = clearing ? clr_cnt : AW'(pipe[NSTG].idx);
  assign wdata = clearing ? '0 : dec_st;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      rd <= mem[AW'(s_idx)];
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      ov       <= 1'b0;
      cnt      <= '0;
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else begin
      if (ld[1]) begin
        vld[1] <= acc;
      end
      for (int k = 2; k <= NSTG; k++) begin
        if (ld[k]) begin
          vld[k] <= vld[k-1];
        end
      end
      if (ld[NSTG+1]) begin
        ov <= vld[NSTG];
      end
      if (go_last) begin
        cnt <= pipe[NSTG].last ? '0 : cnt_next;
      end
      if (clearing) begin
        clr_cnt <= clr_cnt + 1'b1;
        if (clr_cnt == AW'(NEURONS - 1)) begin
          clearing <= 1'b0;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    for (int k = 1; k <= NSTG; k++) begin
      if (ld[k]) begin
        pipe[k] <= nx[k];
      end
    end
    if (ld[NSTG+1]) begin
      o_idx   <= pipe[NSTG].idx;
      o_fired <= dec_fired;
      o_kind  <= dec_kind;
      o_cnt   <= cnt_next;
      o_last  <= pipe[NSTG].last;
    end
  end

  assign m_axis_tvalid = ov;
  assign m_axis_tdata  = {3'd0, o_cnt, o_idx};
  assign m_axis_tuser  = {o_kind, o_fired};
  assign m_axis_tlast  = o_last;

endmodule

// ===== design/tcbn_checker.sv =====
// Port-level checks for the two-compartment burst neuron unit, bound to the top level.
`timescale 1ns / 1ps

module tcbn_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic [3:0]  m_axis_tuser,
  input logic        m_axis_tlast
);
  import tcbn_pkg::*;

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // Fired flag agrees with spike kind
  a_kind: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser[0] == (m_axis_tuser[3:1] != KIND_NONE)))
    else $error("fired flag and spike kind disagree");

  // A spike is included in the reported tick count
  a_count: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> (m_axis_tdata[20:10] != 11'd0))
    else $error("spike reported with zero tick count");

  // No request is taken right after reset while state is cleared
  a_clear: assert property (@(posedge clk)
    $past(rst) |-> !s_axis_tready)
    else $error("request taken during state clearing");

endmodule

bind two_compartment_burst_neuron_unit tcbn_checker u_tcbn_checker (.*);

// ===== tb/sv/tb_two_compartment_burst_neuron_unit.sv =====
// Self-checking testbench for the two-compartment burst neuron unit.
`timescale 1ns / 1ps

module tb_two_compartment_burst_neuron_unit;
  import tcbn_pkg::*;

  localparam int NEURONS    = 1024;
  localparam int IDLE_LIMIT = 4000;
  localparam int HOLD_LEN   = 400;
  localparam int DRAIN      = 20;

  typedef struct {
    logic [9:0]  idx;
    logic [15:0] basal;
    logic [15:0] apical;
    logic [15:0] soma;
    logic        last;
  } update_req_t;

  typedef struct {
    logic [9:0]  id;
    logic        fired;
    spike_kind_t kind;
    logic [10:0] count;
    logic        done;
  } spike_rsp_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic [3:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;

  two_compartment_burst_neuron_unit #(.NEURONS(NEURONS), .VALUE_BITS(16)) i_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  update_req_t pending_reqs[$];
  spike_rsp_t  expected_spikes[$];
  int          errors;
  int          send_idle_pct;
  int          recv_stall_pct;
  logic        hold_armed;
  logic        hold_used;
  int          hold_left;
  int          quiet_cycles;
  logic        req_taken;

  // Neuron model state
  logic [63:0] nrn_regs [7];
  longint      v_soma [NEURONS];
  longint      v_apic [NEURONS];
  longint      w_adapt [NEURONS];
  int          refr_left [NEURONS];
  logic        ca_on [NEURONS];
  int          ca_left [NEURONS];
  int          burst_rem [NEURONS];
  int          ivl_left [NEURONS];
  int          fire_total;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint fld_s16(logic [63:0] r, int pos);
    logic [15:0] u;
    u = 16'(r >> pos);
    return longint'($signed(u));
  endfunction

  function automatic int fld_u16(logic [63:0] r, int pos);
    logic [15:0] u;
    u = 16'(r >> pos);
    return int'(u);
  endfunction

  function automatic longint sat16(longint x);
    if (x > 32767) return 32767;
    if (x < -32768) return -32768;
    return x;
  endfunction

  // Round to nearest, halves up
  function automatic longint round_shr(longint x, int sh);
    longint d;
    longint y;
    longint q;
    d = longint'(1) << sh;
    y = x + d / 2;
    q = y / d;
    if (y % d != 0 && y < 0) q = q - 1;
    return q;
  endfunction

  function automatic longint gmul(longint g, longint v);
    return round_shr(g * v, 12);
  endfunction

  function automatic void soma_integrate(int i, longint drive);
    longint vrest;
    longint va;
    longint sum;
    longint v;
    longint w;
    vrest = fld_s16(nrn_regs[CFG_SOMA_LEVELS], 0);
    v = v_soma[i];
    w = w_adapt[i];
    va = nrn_regs[CFG_APICAL_ENABLE][0] ? v_apic[i] : vrest;
    sum = (vrest - v) + gmul(fld_s16(nrn_regs[CFG_SOMA_GAINS], 16), drive) - w
          + gmul(fld_s16(nrn_regs[CFG_SOMA_GAINS], 32), va - v);
    v = sat16(v + gmul(fld_s16(nrn_regs[CFG_SOMA_GAINS], 0), sum));
    v_soma[i] = v;
    w = sat16(w + gmul(fld_s16(nrn_regs[CFG_ADAPT_GAINS], 32),
                       gmul(fld_s16(nrn_regs[CFG_ADAPT_GAINS], 0), v - vrest) - w));
    w_adapt[i] = w;
  endfunction

  function automatic void apical_advance(int i, longint iap);
    longint vrest;
    longint va;
    longint sum;
    vrest = fld_s16(nrn_regs[CFG_SOMA_LEVELS], 0);
    va = v_apic[i];
    sum = (vrest - va) + gmul(fld_s16(nrn_regs[CFG_APICAL_GAINS], 16), iap)
          + gmul(fld_s16(nrn_regs[CFG_APICAL_GAINS], 32), v_soma[i] - va);
    va = sat16(va + gmul(fld_s16(nrn_regs[CFG_APICAL_GAINS], 0), sum));
    if (ca_left[i] > 0) begin
      ca_left[i]--;
      if (ca_left[i] == 0) ca_on[i] = 1'b0;
    end else if (va >= fld_s16(nrn_regs[CFG_APICAL_LEVELS], 0)) begin
      ca_on[i] = 1'b1;
      ca_left[i] = fld_u16(nrn_regs[CFG_TIMING], 16);
      va = sat16(va + fld_s16(nrn_regs[CFG_APICAL_LEVELS], 16));
    end
    v_apic[i] = va;
  endfunction

  // Advance one neuron by one tick and form its spike report
  function automatic spike_rsp_t neuron_tick(update_req_t r);
    spike_rsp_t o;
    int     i;
    logic   en;
    logic   expired;
    longint vreset;
    longint bj;
    longint drive;
    int     cnt;
    o.id = r.idx;
    o.fired = 1'b0;
    o.kind = KIND_NONE;
    o.done = r.last;
    i = int'(r.idx);
    en = nrn_regs[CFG_APICAL_ENABLE][0];
    vreset = fld_s16(nrn_regs[CFG_SOMA_LEVELS], 32);
    bj = fld_s16(nrn_regs[CFG_ADAPT_GAINS], 16);
    drive = longint'($signed(r.basal)) + longint'($signed(r.soma));
    if (i < NEURONS) begin
      if (en) apical_advance(i, longint'($signed(r.apical)));
      if (burst_rem[i] > 0) begin
        expired = ivl_left[i] <= 1;
        if (!expired) ivl_left[i]--;
        if (refr_left[i] > 0) refr_left[i]--;
        else soma_integrate(i, drive);
        if (expired) begin
          burst_rem[i]--;
          ivl_left[i] = fld_u16(nrn_regs[CFG_TIMING], 48);
          v_soma[i] = vreset;
          w_adapt[i] = sat16(w_adapt[i] + round_shr(bj, 5));
          o.kind = burst_rem[i] == 0 ? KIND_BURST_END : KIND_BURST_CONT;
          o.fired = 1'b1;
        end
      end else if (refr_left[i] > 0) begin
        refr_left[i]--;
      end else begin
        soma_integrate(i, drive);
        if (v_soma[i] >= fld_s16(nrn_regs[CFG_SOMA_LEVELS], 16)) begin
          cnt = fld_u16(nrn_regs[CFG_TIMING], 32);
          v_soma[i] = vreset;
          w_adapt[i] = sat16(w_adapt[i] + round_shr(bj, 4));
          refr_left[i] = fld_u16(nrn_regs[CFG_TIMING], 0);
          if (en && ca_on[i]) begin
            o.kind = KIND_BURST_START;
            burst_rem[i] = cnt > 0 ? cnt - 1 : 0;
            ivl_left[i] = fld_u16(nrn_regs[CFG_TIMING], 48);
          end else begin
            o.kind = KIND_REGULAR;
          end
          o.fired = 1'b1;
        end
      end
    end
    if (o.fired && fire_total < 2047) fire_total++;
    o.count = fire_total[10:0];
    if (r.last) fire_total = 0;
    return o;
  endfunction

  // Sample handshakes, predict, check, watch for a hang
  always @(posedge clk) begin
    spike_rsp_t e;
    req_taken = s_axis_tvalid && s_axis_tready;
    if (rst) begin
      quiet_cycles = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_APICAL_LEVELS: nrn_regs[cfg_index] = {32'd0, cfg_data[31:0]};
          CFG_TIMING:        nrn_regs[cfg_index] = cfg_data;
          CFG_APICAL_ENABLE: nrn_regs[cfg_index] = {63'd0, cfg_data[0]};
          default:           nrn_regs[cfg_index] = {16'd0, cfg_data[47:0]};
        endcase
      end
      if (req_taken)
        expected_spikes.push_back(neuron_tick('{s_axis_tdata[9:0], s_axis_tdata[25:10],
          s_axis_tdata[41:26], s_axis_tdata[57:42], s_axis_tlast}));
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_spikes.size() == 0) begin
          $error("unexpected result id=%0d", m_axis_tdata[9:0]);
          errors++;
        end else begin
          e = expected_spikes.pop_front();
          if (m_axis_tdata[9:0] !== e.id) begin
            $error("neuron_id exp %0d got %0d", e.id, m_axis_tdata[9:0]); errors++;
          end
          if (m_axis_tuser[0] !== e.fired) begin
            $error("fired exp %0d got %0d", e.fired, m_axis_tuser[0]); errors++;
          end
          if (m_axis_tuser[3:1] !== e.kind) begin
            $error("spike_kind exp %0d got %0d", e.kind, m_axis_tuser[3:1]); errors++;
          end
          if (m_axis_tdata[20:10] !== e.count) begin
            $error("tick_fire_count exp %0d got %0d", e.count, m_axis_tdata[20:10]);
            errors++;
          end
          if (m_axis_tlast !== e.done) begin
            $error("tick_done exp %0d got %0d", e.done, m_axis_tlast); errors++;
          end
        end
      end
      if (req_taken || (m_axis_tvalid && m_axis_tready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Offer the next request, with random gaps
  always @(negedge clk) begin
    update_req_t r;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || req_taken) begin
      if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        r = pending_reqs.pop_front();
        s_axis_tdata <= {6'd0, r.soma, r.apical, r.basal, r.idx};
        s_axis_tlast <= r.last;
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Stall the result side at random, once for a long stretch
  always @(negedge clk) begin
    if (hold_armed && !hold_used) begin
      hold_left = HOLD_LEN;
      hold_used = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= $urandom_range(0, 99) >= recv_stall_pct;
    end
  end

  task automatic write_reg(cfg_index_t idx, logic [63:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic write_all(logic [63:0] v0, logic [63:0] v1, logic [63:0] v2,
                           logic [63:0] v3, logic [63:0] v4, logic [63:0] v5,
                           logic [63:0] v6);
    write_reg(CFG_SOMA_LEVELS, v0);
    write_reg(CFG_SOMA_GAINS, v1);
    write_reg(CFG_ADAPT_GAINS, v2);
    write_reg(CFG_APICAL_LEVELS, v3);
    write_reg(CFG_APICAL_GAINS, v4);
    write_reg(CFG_TIMING, v5);
    write_reg(CFG_APICAL_ENABLE, v6);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Plausible biophysical setting: rest -65, threshold -50, reset -70
  task automatic write_tuned(logic [15:0] refr, logic [15:0] ca_dur, logic [15:0] bcnt,
                             logic [15:0] ivl, logic en);
    write_all(64'h0000_BA00_CE00_BF00, 64'h0000_0333_1000_019A,
              64'h0000_00CD_2000_0029, 64'h0000_0000_0A00_D300,
              64'h0000_019A_1000_019A, {ivl, bcnt, ca_dur, refr}, {63'd0, en});
  endtask

  function automatic logic [15:0] rand_current();
    if ($urandom_range(0, 4) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 6000)) - 16'd1500;
  endfunction

  // Mostly ticks over a small neuron group, some stray indexes
  task automatic queue_ticks(int n);
    int pos;
    update_req_t r;
    pos = 0;
    repeat (n) begin
      if ($urandom_range(0, 9) < 8) begin
        r.idx = 10'(pos % 8);
        r.last = (pos % 8) == 7;
        pos++;
      end else begin
        r.idx = 10'($urandom_range(0, 1023));
        r.last = 1'($urandom);
      end
      r.basal = rand_current();
      r.apical = rand_current();
      r.soma = rand_current();
      pending_reqs.push_back(r);
    end
  endtask

  task automatic drain();
    while (pending_reqs.size() != 0 || s_axis_tvalid || expected_spikes.size() != 0)
      @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic set_idle(int ph);
    case (ph % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
      default: begin send_idle_pct = 35; recv_stall_pct = 35; end
    endcase
  endtask

  initial begin
    update_req_t r;
    errors = 0;
    fire_total = 0;
    foreach (nrn_regs[k]) nrn_regs[k] = '0;
    for (int k = 0; k < NEURONS; k++) begin
      v_soma[k] = 0; v_apic[k] = 0; w_adapt[k] = 0; refr_left[k] = 0;
      ca_on[k] = 1'b0; ca_left[k] = 0; burst_rem[k] = 0; ivl_left[k] = 0;
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_armed = 1'b0;
    hold_used = 1'b0;
    hold_left = 0;
    quiet_cycles = 0;
    req_taken = 1'b0;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    m_axis_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_SOMA_LEVELS;
    cfg_data = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: field extremes, repeats of three neurons, the top index 1023, tick ends
    write_tuned(16'd2, 16'd3, 16'd3, 16'd2, 1'b1);
    for (int k = 0; k < 20; k++) begin
      r.idx = (k % 5 == 4) ? 10'd1023 : 10'(k % 3);
      r.basal = (k % 4 == 0) ? 16'h7FFF : (k % 4 == 1) ? 16'h8000 : 16'h1400;
      r.apical = (k % 3 == 0) ? 16'h7FFF : (k % 3 == 1) ? 16'h8000 : 16'h2000;
      r.soma = (k % 2 == 0) ? 16'h7FFF : 16'h0000;
      r.last = (k % 6 == 5);
      pending_reqs.push_back(r);
    end
    drain();

    // Random phases over several settings, with the long output hold in the first
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_tuned(16'd2, 16'd5, 16'd3, 16'd2, 1'b1);
        1: write_tuned(16'd0, 16'd0, 16'($urandom_range(0, 1)), 16'd0, 1'b1);
        2: write_tuned(16'd1, 16'd4, 16'd4, 16'd3, 1'b0);
        3: write_all({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                     {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                     64'($urandom));
        4: write_all('1, '1, '1, '1, '1, '1, '1);
        default: write_tuned(16'd3, 16'd8, 16'd6, 16'd1, 1'b1);
      endcase
      set_idle(ph);
      if (ph == 0) hold_armed = 1'b1;
      queue_ticks(55);
      drain();
    end

    // All-zero setting fires most updates: run one long tick of spikes
    write_all('0, '0, '0, '0, '0, '0, '0);
    set_idle(0);
    for (int k = 0; k < 100; k++) begin
      r.idx = 10'($urandom_range(0, 1023));
      r.basal = 16'($urandom);
      r.apical = 16'($urandom);
      r.soma = 16'($urandom);
      r.last = (k == 99);
      pending_reqs.push_back(r);
    end
    drain();

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
